FILE: rtl/core/ipv4_fragment_header_gen_core_defines.svh
// Assertion macros used by the checker file of the fragment header core.
`ifndef IPV4_FRAGMENT_HEADER_GEN_CORE_DEFINES_SVH
`define IPV4_FRAGMENT_HEADER_GEN_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FHG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fragment header core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FHG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fragment header core: next-cycle check failed");

`endif

FILE: rtl/core/ipv4fhg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 fragment header generator package
// Shared types, register indexes and header constants.
// ----------------------------------------------------------------------------
package ipv4fhg_pkg;

    localparam int unsigned CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CFG_LOCAL_ADDRESS   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_SUBNET_MASK     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_GATEWAY_ADDRESS = 2'd2;

    localparam logic [15:0] HDR_BYTES   = 16'd60;
    localparam logic [15:0] MAX_LEN     = 16'd65475;
    localparam logic [15:0] VER_IHL_TOS = 16'h4ffe;
    localparam logic [15:0] TTL_PROTO   = 16'h4006;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SUM,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic sum;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic last;
        logic out_free;
    } t_status;

    function automatic logic [15:0] fold19(input logic [18:0] s);
        logic [16:0] f1;
        logic [16:0] f2;
        begin
            f1 = {1'b0, s[15:0]} + {14'd0, s[18:16]};
            f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
            fold19 = f2[15:0];
        end
    endfunction

endpackage

FILE: rtl/core/ipv4fhg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 fragment header controller
// Sequences request load, checksum setup and one fragment per free output slot.
// ----------------------------------------------------------------------------
module ipv4fhg_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ipv4fhg_pkg::t_status i_status,
    output ipv4fhg_pkg::t_cmd    o_cmd
);

    ipv4fhg_pkg::t_state r_state;
    ipv4fhg_pkg::t_state n_state;
    logic                accept;

    assign accept = i_in_valid && (r_state == ipv4fhg_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ipv4fhg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ipv4fhg_pkg::ST_IDLE: begin
                if (accept && !i_status.len_zero) begin
                    n_state = ipv4fhg_pkg::ST_SETUP;
                end
            end
            ipv4fhg_pkg::ST_SETUP: begin
                n_state = ipv4fhg_pkg::ST_SUM;
            end
            ipv4fhg_pkg::ST_SUM: begin
                n_state = ipv4fhg_pkg::ST_EMIT;
            end
            ipv4fhg_pkg::ST_EMIT: begin
                if (i_status.out_free && i_status.last) begin
                    n_state = ipv4fhg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ipv4fhg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        o_cmd.load  = 1'b0;
        o_cmd.setup = 1'b0;
        o_cmd.sum   = 1'b0;
        o_cmd.emit  = 1'b0;
        case (r_state)
            ipv4fhg_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = accept;
            end
            ipv4fhg_pkg::ST_SETUP: begin
                o_cmd.setup = 1'b1;
            end
            ipv4fhg_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
            end
            ipv4fhg_pkg::ST_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/core/ipv4fhg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 fragment header datapath
// Holds configuration, the identification counter, fragment progress and
// the output word register with its checksum logic.
// ----------------------------------------------------------------------------
module ipv4fhg_datapath #(
    parameter int unsigned FRAG_PAYLOAD = 1440
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ipv4fhg_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    input  logic [15:0]                         i_payload_length,
    input  logic [31:0]                         i_target_address,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [31:0]                         o_dest_address,
    output logic [15:0]                         o_packet_length,
    output logic [15:0]                         o_flags_offset,
    output logic [15:0]                         o_identification,
    output logic [15:0]                         o_header_checksum,
    output logic [15:0]                         o_payload_start,
    output logic                                o_last_fragment,
    input  ipv4fhg_pkg::t_cmd                   i_cmd,
    output ipv4fhg_pkg::t_status                o_status
);

    localparam logic [15:0] FragLen = 16'(FRAG_PAYLOAD);

    logic [31:0] r_local;
    logic [31:0] r_mask;
    logic [31:0] r_gateway;
    logic [15:0] r_datagram_id;
    logic [31:0] r_dst;
    logic [15:0] r_id;
    logic [15:0] r_rest;
    logic [15:0] r_offset;
    logic [17:0] r_acc;
    logic [15:0] r_base;
    logic        r_out_valid;

    logic [15:0] len_sat;
    logic [31:0] dst_sel;
    logic        last;
    logic [15:0] flen;
    logic [15:0] total;
    logic [15:0] fo;
    logic [17:0] frag_sum;
    logic [18:0] base_sum;
    logic [15:0] csum;

    assign len_sat = (i_payload_length > ipv4fhg_pkg::MAX_LEN) ?
                     ipv4fhg_pkg::MAX_LEN : i_payload_length;
    assign dst_sel = ((r_local & r_mask) == (i_target_address & r_mask)) ?
                     i_target_address : r_gateway;

    assign last     = (r_rest <= FragLen);
    assign flen     = last ? r_rest : FragLen;
    assign total    = flen + ipv4fhg_pkg::HDR_BYTES;
    assign fo       = {2'b00, !last, r_offset[15:3]};
    assign frag_sum = {2'b00, r_base} + {2'b00, total} + {2'b00, fo};
    assign csum     = ~ipv4fhg_pkg::fold19({1'b0, frag_sum});
    assign base_sum = {1'b0, r_acc} + {3'b000, r_dst[31:16]} + {3'b000, r_dst[15:0]};

    assign o_status.len_zero = (i_payload_length == 16'd0);
    assign o_status.last     = last;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local       <= 32'd0;
            r_mask        <= 32'd0;
            r_gateway     <= 32'd0;
            r_datagram_id <= 16'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ipv4fhg_pkg::CFG_LOCAL_ADDRESS:   r_local   <= i_cfg_data;
                    ipv4fhg_pkg::CFG_SUBNET_MASK:     r_mask    <= i_cfg_data;
                    ipv4fhg_pkg::CFG_GATEWAY_ADDRESS: r_gateway <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_datagram_id <= r_datagram_id + 16'd1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dst    <= dst_sel;
            r_id     <= r_datagram_id;
            r_rest   <= len_sat;
            r_offset <= 16'd0;
        end
        if (i_cmd.setup) begin
            r_acc <= {2'b00, ipv4fhg_pkg::VER_IHL_TOS} + {2'b00, ipv4fhg_pkg::TTL_PROTO} +
                     {2'b00, r_local[31:16]} + {2'b00, r_local[15:0]} + {2'b00, r_id};
        end
        if (i_cmd.sum) begin
            r_base <= ipv4fhg_pkg::fold19(base_sum);
        end
        if (i_cmd.emit) begin
            o_dest_address    <= r_dst;
            o_packet_length   <= total;
            o_flags_offset    <= fo;
            o_identification  <= r_id;
            o_header_checksum <= csum;
            o_payload_start   <= r_offset;
            o_last_fragment   <= last;
            r_rest            <= r_rest - FragLen;
            r_offset          <= r_offset + FragLen;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/core/ipv4_fragment_header_gen_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 fragment header generator core
// Turns one send request into one 60-byte IPv4 header word per fragment.
// ----------------------------------------------------------------------------
// A request with a nonzero length is taken and its destination is chosen; the
// fixed part of the header checksum is then summed in the SETUP and SUM
// states, then one fragment header word is loaded per cycle in which the
// output register is free, ceil(length / FRAG_PAYLOAD) words in all (at most
// 46 with the default FRAG_PAYLOAD, since the length saturates at 65475).
// A zero-length request is taken and yields no word; every request advances
// the identification counter. The next request is taken once the last
// fragment word has entered the output register.
module ipv4_fragment_header_gen_core #(
    parameter int unsigned FRAG_PAYLOAD = 1440
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_payload_length,
    input  logic [31:0] i_target_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_dest_address,
    output logic [15:0] o_packet_length,
    output logic [15:0] o_flags_offset,
    output logic [15:0] o_identification,
    output logic [15:0] o_header_checksum,
    output logic [15:0] o_payload_start,
    output logic        o_last_fragment
);

    ipv4fhg_pkg::t_cmd    cmd;
    ipv4fhg_pkg::t_status status;

    ipv4fhg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ipv4fhg_datapath #(
        .FRAG_PAYLOAD (FRAG_PAYLOAD)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_payload_length  (i_payload_length),
        .i_target_address  (i_target_address),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_dest_address    (o_dest_address),
        .o_packet_length   (o_packet_length),
        .o_flags_offset    (o_flags_offset),
        .o_identification  (o_identification),
        .o_header_checksum (o_header_checksum),
        .o_payload_start   (o_payload_start),
        .o_last_fragment   (o_last_fragment),
        .i_cmd             (cmd),
        .o_status          (status)
    );

endmodule

FILE: rtl/core/ipv4fhg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 fragment header checker
// Port-level checks of the fragment header core, bound to the top level.
// ----------------------------------------------------------------------------
`include "ipv4_fragment_header_gen_core_defines.svh"

module ipv4fhg_checker #(
    parameter int unsigned FRAG_PAYLOAD = 1440
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [15:0] i_payload_length,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_packet_length,
    input logic [15:0] o_flags_offset,
    input logic [15:0] o_payload_start,
    input logic        o_last_fragment
);

    localparam logic [15:0] MaxTotal = 16'(FRAG_PAYLOAD + 60);

    logic        out_wait;
    logic [31:0] out_pair;
    logic        in_take;
    logic        len_ok;
    logic        mf_ok;

    assign out_wait = o_out_valid && i_out_stall;
    assign out_pair = {o_packet_length, o_payload_start};
    assign in_take  = i_in_valid && !o_in_stall && (i_payload_length != 16'd0);
    assign len_ok   = (o_packet_length > 16'd60) && (o_packet_length <= MaxTotal);
    assign mf_ok    = (o_flags_offset[13] != o_last_fragment);

    `FHG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(out_pair))
    `FHG_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_take, o_in_stall)
    `FHG_ASSERT_SAME(a_total_range, i_clk, i_rst_n, o_out_valid, len_ok)
    `FHG_ASSERT_SAME(a_mf_vs_last, i_clk, i_rst_n, o_out_valid, mf_ok)

endmodule

bind ipv4_fragment_header_gen_core ipv4fhg_checker #(
    .FRAG_PAYLOAD (FRAG_PAYLOAD)
) u_ipv4fhg_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_payload_length (i_payload_length),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_packet_length  (o_packet_length),
    .o_flags_offset   (o_flags_offset),
    .o_payload_start  (o_payload_start),
    .o_last_fragment  (o_last_fragment)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 fragment header generator testbench
// Sends send requests through the valid/stall input channel, predicts every
// fragment header word from its own copy of the address registers and the
// identification counter, and checks each accepted output word in order.
// Directed tests cover fragment boundaries, length saturation, routing and
// the unused register index, followed by random requests under several
// network settings with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned FRAG_BYTES  = 1440;
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned IDLE_WAIT   = 12;
    localparam int unsigned TAIL_WAIT   = 20;

    localparam logic [1:0]  CFG_SPARE = 2'd3;
    localparam logic [15:0] MF_FLAG   = 16'h2000;
    localparam logic [15:0] OFF_MASK  = 16'h1fff;

    typedef struct {
        logic [31:0] dest;
        logic [15:0] total;
        logic [15:0] flags_off;
        logic [15:0] ident;
        logic [15:0] csum;
        logic [15:0] start;
        logic        last;
    } t_frag_hdr;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_payload_length = '0;
    logic [31:0] i_target_address = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_dest_address;
    logic [15:0] o_packet_length;
    logic [15:0] o_flags_offset;
    logic [15:0] o_identification;
    logic [15:0] o_header_checksum;
    logic [15:0] o_payload_start;
    logic        o_last_fragment;

    logic [31:0] net_own = '0;
    logic [31:0] net_mask = '0;
    logic [31:0] net_gateway = '0;
    logic [15:0] next_id = '0;

    t_frag_hdr   header_q[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned stall_span = 0;
    int unsigned stall_pct = 0;

    ipv4_fragment_header_gen_core #(
        .FRAG_PAYLOAD(FRAG_BYTES)
    ) dut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_span = $urandom_range(20, 120);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 50;
                default: stall_pct = 80;
            endcase
        end
        stall_span--;
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic logic [15:0] header_checksum(input logic [15:0] total,
                                                    input logic [15:0] ident,
                                                    input logic [15:0] flags_off,
                                                    input logic [31:0] src,
                                                    input logic [31:0] dst);
        logic [31:0] acc;
        acc = 32'(ipv4fhg_pkg::VER_IHL_TOS) + 32'(total) + 32'(ident) + 32'(flags_off)
            + 32'(ipv4fhg_pkg::TTL_PROTO) + 32'(src[31:16]) + 32'(src[15:0])
            + 32'(dst[31:16]) + 32'(dst[15:0]);
        while (acc[31:16] != 16'd0) acc = 32'(acc[15:0]) + 32'(acc[31:16]);
        return ~acc[15:0];
    endfunction

    function automatic void predict_headers(input logic [15:0] req_len,
                                            input logic [31:0] target);
        t_frag_hdr   hdr;
        logic [31:0] len;
        logic [31:0] offset;
        logic [31:0] rest;
        logic [31:0] dst;
        logic        last;
        len = (req_len > ipv4fhg_pkg::MAX_LEN) ? 32'(ipv4fhg_pkg::MAX_LEN) : 32'(req_len);
        dst = ((net_own & net_mask) == (target & net_mask)) ? target : net_gateway;
        offset = 0;
        while (offset < len) begin
            rest = len - offset;
            last = (rest <= FRAG_BYTES);
            hdr.dest = dst;
            hdr.total = 16'(last ? rest : FRAG_BYTES) + ipv4fhg_pkg::HDR_BYTES;
            hdr.flags_off = (offset[18:3] & OFF_MASK) | (last ? 16'd0 : MF_FLAG);
            hdr.ident = next_id;
            hdr.csum = header_checksum(hdr.total, next_id, hdr.flags_off, net_own, dst);
            hdr.start = offset[15:0];
            hdr.last = last;
            header_q.push_back(hdr);
            if (last) break;
            offset += FRAG_BYTES;
        end
        next_id = next_id + 16'd1;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_output
        t_frag_hdr exp_hdr;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (header_q.size() == 0) begin
                $error("header word with no pending expectation, dest %h", o_dest_address);
                fail_count++;
            end else begin
                exp_hdr = header_q.pop_front();
                check_field("dest_address", exp_hdr.dest, o_dest_address);
                check_field("packet_length", 32'(exp_hdr.total), 32'(o_packet_length));
                check_field("flags_offset", 32'(exp_hdr.flags_off), 32'(o_flags_offset));
                check_field("identification", 32'(exp_hdr.ident), 32'(o_identification));
                check_field("header_checksum", 32'(exp_hdr.csum), 32'(o_header_checksum));
                check_field("payload_start", 32'(exp_hdr.start), 32'(o_payload_start));
                check_field("last_fragment", 32'(exp_hdr.last), 32'(o_last_fragment));
            end
        end
    end

    task automatic send_request(input logic [15:0] len, input logic [31:0] target);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_payload_length <= len;
        i_target_address <= target;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_headers(len, target);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (header_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            ipv4fhg_pkg::CFG_LOCAL_ADDRESS: net_own = data;
            ipv4fhg_pkg::CFG_SUBNET_MASK: net_mask = data;
            ipv4fhg_pkg::CFG_GATEWAY_ADDRESS: net_gateway = data;
            default: ;
        endcase
    endtask

    task automatic set_network(input logic [31:0] own, input logic [31:0] mask,
                               input logic [31:0] gateway);
        settle();
        cfg_write(ipv4fhg_pkg::CFG_LOCAL_ADDRESS, own);
        cfg_write(ipv4fhg_pkg::CFG_SUBNET_MASK, mask);
        cfg_write(ipv4fhg_pkg::CFG_GATEWAY_ADDRESS, gateway);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_request(16'd1, 32'hffffffff);
        send_request(16'd1440, 32'h00000000);
        send_request(16'd1441, 32'h12345678);
        send_request(16'd0, 32'h87654321);
    endtask

    task automatic test_length_extremes();
        set_network(32'h0a000001, 32'hff000000, 32'h0a0000fe);
        send_request(16'd8, 32'h0a010203);
        send_request(16'd1439, 32'h0a010203);
        send_request(16'd2880, 32'h0b010203);
        send_request(16'd2881, 32'h0a010203);
        send_request(ipv4fhg_pkg::MAX_LEN, 32'h0a7f7f7f);
        send_request(ipv4fhg_pkg::MAX_LEN + 16'd1, 32'h0b000000);
        send_request(16'hffff, 32'h0affffff);
        send_request(16'd0, 32'h0a000002);
        send_request(16'd0, 32'h0a000003);
        send_request(16'd1, 32'h0a000004);
    endtask

    task automatic test_routing();
        set_network(32'hc0a80105, 32'hffffff00, 32'hc0a801fe);
        send_request(16'd100, 32'hc0a80142);
        send_request(16'd3000, 32'h08080808);
        set_network(32'hc0a80105, 32'hffffffff, 32'hfffffffe);
        send_request(16'd200, 32'hc0a80105);
        send_request(16'd200, 32'hc0a80104);
        set_network(32'hffffffff, 32'h00000000, 32'h01020304);
        send_request(16'd1500, 32'h5a5aa5a5);
    endtask

    task automatic test_unused_index();
        set_network(32'hac100001, 32'hfff00000, 32'hac100101);
        cfg_write(CFG_SPARE, 32'hdeadbeef);
        i_cfg_we <= 1'b0;
        send_request(16'd700, 32'hac1f0001);
        send_request(16'd700, 32'hac200001);
    endtask

    task automatic send_random_request();
        logic [15:0] len;
        logic [31:0] target;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8) len = 16'd0;
        else if (pick < 65) len = 16'($urandom_range(1, 3000));
        else if (pick < 88) len = 16'($urandom_range(3001, 20000));
        else len = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 1) target = (net_own & net_mask) | ($urandom & ~net_mask);
        else target = $urandom;
        send_request(len, target);
    endtask

    task automatic test_random();
        logic [31:0] mask;
        int unsigned prefix;
        for (int phase = 0; phase < 6; phase++) begin
            prefix = $urandom_range(1, 32);
            mask = 32'hffffffff << (32 - prefix);
            case (phase)
                1: set_network(32'hffffffff, 32'hffffffff, 32'hffffffff);
                2: set_network($urandom, 32'h00000000, $urandom);
                3: set_network($urandom, 32'hffffffff, $urandom);
                default: set_network($urandom, mask, $urandom);
            endcase
            repeat (68) send_random_request();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_length_extremes();
        test_routing();
        test_unused_index();
        test_random();
        settle();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
